// ===== design/stwt_pkg.sv =====
// Shared types and constants for the slot table with timeouts.
// Used by stwt_front, stwt_back and slot_table_with_timeouts_core.
package stwt_pkg;

  // Table depth. The slot index and active count widths below are sized for it.
  localparam int SLOTS    = 16;

  localparam int CMD_W    = 2;
  localparam int DATA_W   = 32;
  localparam int TICKS_W  = 16;
  localparam int SLOT_W   = 4;
  localparam int ACTIVE_W = 5;

  localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 16'd30000;

  // Command codes on the input channel.
  localparam logic [CMD_W-1:0] CMD_REGISTER   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UNREGISTER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK       = 2'd2;

  // Result kinds on the output channel.
  localparam logic [1:0] KIND_REGISTER   = 2'd0;
  localparam logic [1:0] KIND_UNREGISTER = 2'd1;
  localparam logic [1:0] KIND_EXPIRY     = 2'd2;

  typedef enum logic [1:0] {
    OP_REGISTER,
    OP_UNREGISTER,
    OP_TICK
  } op_t;

  // One queued command between the front and the back.
  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] owner;
    logic [DATA_W-1:0] socket;
  } entry_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic                ok;
    logic [SLOT_W-1:0]   slot;
    logic [DATA_W-1:0]   owner;
    logic [DATA_W-1:0]   socket;
    logic [ACTIVE_W-1:0] active_count;
    logic                last_flag;
  } result_t;

endpackage

// ===== design/stwt_front.sv =====
// Front end: takes input transfers, decodes the command and queues it.
// Depends on stwt_pkg for the command codes and the queue entry type.
module stwt_front
  import stwt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [DATA_W-1:0] owner_id,
  input  logic [DATA_W-1:0] socket_handle,
  output logic              q_valid,
  output entry_t            q_head,
  input  logic              q_pop
);

  entry_t     ent [2];
  logic [1:0] count;
  logic       take;
  logic       push;
  entry_t     decoded;

  // The unused command code is taken from the channel and dropped here.
  always_comb begin
    decoded.owner  = owner_id;
    decoded.socket = socket_handle;
    decoded.op     = OP_TICK;
    push           = 1'b0;
    case (cmd)
      CMD_REGISTER: begin
        decoded.op = OP_REGISTER;
        push       = 1'b1;
      end
      CMD_UNREGISTER: begin
        decoded.op = OP_UNREGISTER;
        push       = 1'b1;
      end
      CMD_TICK: begin
        decoded.op = OP_TICK;
        push       = 1'b1;
      end
      default: push = 1'b0;
    endcase
  end

  assign in_stall = (count == 2'd2);
  assign take     = in_valid && !in_stall && push;
  assign q_valid  = (count != 2'd0);
  assign q_head   = ent[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({take, q_pop && q_valid})
        2'b10: begin
          ent[count[0]] <= decoded;
          count         <= count + 2'd1;
        end
        2'b01: begin
          ent[0] <= ent[1];
          count  <= count - 2'd1;
        end
        2'b11: begin
          if (count == 2'd1) begin
            ent[0] <= decoded;
          end else begin
            ent[0] <= ent[1];
            ent[1] <= decoded;
          end
        end
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/stwt_back.sv =====
// Back end: slot storage, lowest-free search, owner scan, tick scan and the
// output register. Depends on stwt_pkg for the entry and result types.
module stwt_back
  import stwt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [TICKS_W-1:0] timeout_ticks,
  input  logic               q_valid,
  input  entry_t             q_head,
  output logic               q_pop,
  output result_t            res,
  output logic               res_valid,
  input  logic               res_stall
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_REG,
    S_UNREG,
    S_TICK
  } state_t;

  state_t state;

  logic [DATA_W-1:0]  mem_owner  [SLOTS];
  logic [DATA_W-1:0]  mem_socket [SLOTS];
  logic [TICKS_W-1:0] mem_cnt    [SLOTS];

  logic [SLOTS-1:0]  valid_bits;
  logic [SLOTS-1:0]  zero_bits;
  logic [SLOTS-1:0]  exp_mask;
  logic [CW-1:0]     used;
  logic [DATA_W-1:0] cur_owner;
  logic [DATA_W-1:0] cur_socket;

  // Scan pipeline: iss is the next slot to read, rd_* is the slot just read.
  logic [CW-1:0]      iss;
  logic               rd_vld;
  logic [IW-1:0]      rd_idx;
  logic [DATA_W-1:0]  rd_owner;
  logic [DATA_W-1:0]  rd_socket;
  logic [TICKS_W-1:0] rd_cnt;

  logic               free_found;
  logic [IW-1:0]      free_idx;
  logic               out_free;
  logic               match;
  logic               exp_hit;
  logic [SLOTS-1:0]   exp_rest;
  logic               advance;
  logic               scan_done;
  logic               rd_en;
  logic               wr_new;
  logic               dec_we;
  logic               exp_emit;
  logic [CW-1:0]      used_inc;
  logic [CW-1:0]      used_dec;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_bits[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  assign out_free  = !res_valid || !res_stall;
  assign match     = rd_vld && valid_bits[rd_idx] && (rd_owner == cur_owner);
  assign exp_hit   = rd_vld && exp_mask[rd_idx];
  assign exp_rest  = exp_mask & ~(SLOTS'(1) << rd_idx);
  assign advance   = !(((state == S_UNREG) && match) || ((state == S_TICK) && exp_hit))
                     || out_free;
  assign scan_done = (iss == CW'(SLOTS)) && !rd_vld;
  assign rd_en     = ((state == S_UNREG) || (state == S_TICK)) && advance
                     && (iss < CW'(SLOTS));
  assign wr_new    = (state == S_REG) && out_free && free_found;
  assign dec_we    = (state == S_TICK) && rd_vld && !exp_mask[rd_idx] && valid_bits[rd_idx];
  assign exp_emit  = (state == S_TICK) && exp_hit && out_free;
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign used_inc  = used + CW'(1);
  assign used_dec  = used - CW'(1);

  always_ff @(posedge clk) begin
    if (wr_new) begin
      mem_owner[free_idx]  <= cur_owner;
      mem_socket[free_idx] <= cur_socket;
      mem_cnt[free_idx]    <= timeout_ticks;
    end else if (dec_we) begin
      mem_cnt[rd_idx] <= rd_cnt - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_owner  <= mem_owner[iss[IW-1:0]];
      rd_socket <= mem_socket[iss[IW-1:0]];
      rd_cnt    <= mem_cnt[iss[IW-1:0]];
    end
  end

  // A zero flag per slot marks the slots that expire on the next tick.
  always_ff @(posedge clk) begin
    if (wr_new) begin
      zero_bits[free_idx] <= (timeout_ticks == '0);
    end else if (dec_we) begin
      zero_bits[rd_idx] <= (rd_cnt == 16'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid_bits <= '0;
      used       <= '0;
      res_valid  <= 1'b0;
      rd_vld     <= 1'b0;
      iss        <= '0;
    end else begin
      if (out_free) begin
        res_valid <= 1'b0;
      end
      if (rd_en) begin
        rd_vld <= 1'b1;
        rd_idx <= iss[IW-1:0];
        iss    <= iss + CW'(1);
      end else if (advance) begin
        rd_vld <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur_owner  <= q_head.owner;
            cur_socket <= q_head.socket;
            iss        <= '0;
            rd_vld     <= 1'b0;
            exp_mask   <= valid_bits & zero_bits;
            case (q_head.op)
              OP_REGISTER:   state <= S_REG;
              OP_UNREGISTER: state <= S_UNREG;
              OP_TICK:       state <= S_TICK;
              default:       state <= S_IDLE;
            endcase
          end
        end
        S_REG: begin
          if (out_free) begin
            res_valid        <= 1'b1;
            res.kind         <= KIND_REGISTER;
            res.ok           <= free_found;
            res.slot         <= free_found ? SLOT_W'(free_idx) : '0;
            res.owner        <= '0;
            res.socket       <= '0;
            res.active_count <= free_found ? ACTIVE_W'(used_inc) : ACTIVE_W'(used);
            res.last_flag    <= 1'b1;
            if (free_found) begin
              valid_bits[free_idx] <= 1'b1;
              used                 <= used_inc;
            end
            state <= S_IDLE;
          end
        end
        S_UNREG: begin
          if (match) begin
            if (out_free) begin
              res_valid          <= 1'b1;
              res.kind           <= KIND_UNREGISTER;
              res.ok             <= 1'b1;
              res.slot           <= SLOT_W'(rd_idx);
              res.owner          <= '0;
              res.socket         <= '0;
              res.active_count   <= ACTIVE_W'(used_dec);
              res.last_flag      <= 1'b1;
              valid_bits[rd_idx] <= 1'b0;
              used               <= used_dec;
              rd_vld             <= 1'b0;
              state              <= S_IDLE;
            end
          end else if (scan_done && out_free) begin
            res_valid        <= 1'b1;
            res.kind         <= KIND_UNREGISTER;
            res.ok           <= 1'b0;
            res.slot         <= '0;
            res.owner        <= '0;
            res.socket       <= '0;
            res.active_count <= ACTIVE_W'(used);
            res.last_flag    <= 1'b1;
            state            <= S_IDLE;
          end
        end
        S_TICK: begin
          if (exp_hit) begin
            if (out_free) begin
              res_valid          <= 1'b1;
              res.kind           <= KIND_EXPIRY;
              res.ok             <= 1'b1;
              res.slot           <= SLOT_W'(rd_idx);
              res.owner          <= rd_owner;
              res.socket         <= rd_socket;
              res.active_count   <= ACTIVE_W'(used_dec);
              res.last_flag      <= (exp_rest == '0);
              valid_bits[rd_idx] <= 1'b0;
              used               <= used_dec;
              exp_mask           <= exp_rest;
            end
          end else if (scan_done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_used_matches: assert property (@(posedge clk) disable iff (rst)
    used == CW'($countones(valid_bits)))
    else $error("slot count disagrees with the valid bits");

  a_expiry_frees: assert property (@(posedge clk) disable iff (rst)
    exp_emit |=> !valid_bits[$past(rd_idx)])
    else $error("expired slot is still marked valid");

  a_idle_no_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !rd_vld)
    else $error("scan read left in flight while idle");

endmodule

// ===== design/slot_table_with_timeouts_core.sv =====
// Slot table with aging timeouts: top level.
// Depends on stwt_pkg, stwt_front and stwt_back.
//
// Usage: the input channel (in_valid/in_stall) carries cmd, owner_id and
// socket_handle. Register takes the lowest free slot, unregister frees the
// lowest valid slot of a matching owner, and a tick ages every valid slot and
// expires those whose count was already zero. The output channel
// (out_valid/out_stall) carries one result per register or unregister and one
// expiry report per expired slot, in slot order, with last_flag on the final
// one. A tick with no expiry and the unused command code give no result.
// Timing: a two-entry queue sits between the input channel and the engine.
// Unregister and tick walk the slot storage one slot per cycle through a
// registered read port, stopping while a result waits on a stalled output.
// Reset empties the table and loads timeout_ticks with 30000. While out_stall
// holds a result back, the engine waits before giving the next one; the queue
// keeps taking transfers until it is full. The cfg channel is always ready
// and writes timeout_ticks.
module slot_table_with_timeouts_core
  import stwt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [TICKS_W-1:0]  cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [DATA_W-1:0]   owner_id,
  input  logic [DATA_W-1:0]   socket_handle,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          kind,
  output logic                ok,
  output logic [SLOT_W-1:0]   slot,
  output logic [DATA_W-1:0]   out_owner,
  output logic [DATA_W-1:0]   out_socket,
  output logic [ACTIVE_W-1:0] active_count,
  output logic                last_flag
);

  logic [TICKS_W-1:0] timeout_ticks;
  logic               q_valid;
  logic               q_pop;
  entry_t             q_head;
  result_t            res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_ticks <= cfg_data;
    end
  end

  stwt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .owner_id      (owner_id),
    .socket_handle (socket_handle),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop)
  );

  stwt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .timeout_ticks (timeout_ticks),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .res           (res),
    .res_valid     (out_valid),
    .res_stall     (out_stall)
  );

  assign kind         = res.kind;
  assign ok           = res.ok;
  assign slot         = res.slot;
  assign out_owner    = res.owner;
  assign out_socket   = res.socket;
  assign active_count = res.active_count;
  assign last_flag    = res.last_flag;

endmodule
